// ===== rtl/core/bpi_pkg.sv =====
// ----------------------------------------------------------------------------
// bpi_pkg
// Shared types and constants for the wrapped breakpoint interpolator: word
// layouts, command and register codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bpi_pkg;

    // table capacity
    localparam int MAX_STATIONS = 16;

    // field widths
    localparam int POS_W      = 28;
    localparam int VAL_W      = 16;
    localparam int QRY_W      = 32;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 28;

    // shared divider: 45-bit dividend covers the largest product magnitude
    localparam int DIV_W      = 45;
    localparam int DIV_CNT_W  = 6;
    localparam int PROD_W     = VAL_W + 1 + POS_W + 1;
    localparam int WRAP_PAD   = DIV_W - QRY_W;
    localparam logic [DIV_CNT_W-1:0] WRAP_ITERS   = DIV_CNT_W'(QRY_W);
    localparam logic [DIV_CNT_W-1:0] INTERP_ITERS = DIV_CNT_W'(DIV_W);

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_COUNT = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [IDX_W-1:0]        station_index;
        logic [POS_W-1:0]        station_position;
        logic signed [VAL_W-1:0] station_value;
        logic signed [QRY_W-1:0] query_position;
    } bpi_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample_value;
        logic [POS_W-1:0]        wrapped_position;
    } bpi_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_WRAP_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } bpi_state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ENTRY,
        RES_INTERP
    } bpi_res_t;

    typedef struct packed {
        logic     accept;
        logic     wrap_start;
        logic     wrap_latch;
        logic     rd_en;
        logic     scan_adv;
        logic     mul_en;
        logic     interp_start;
        logic     res_load;
        bpi_res_t res_sel;
        logic     out_load;
    } bpi_cmd_t;

    typedef struct packed {
        logic sample_cmd;
        logic len_zero;
        logic n_zero;
        logic div_busy;
        logic div_done;
        logic hit;
        logic k_zero;
        logic last;
        logic out_free;
    } bpi_sts_t;

endpackage

// ===== rtl/core/wrapped_breakpoint_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// wrapped_breakpoint_interpolator_top
// Piecewise linear lookup over a breakpoint table with lap wrapping.
//
// Input channel s_*: one word is a write (load a breakpoint, no result) or a
// sample (returns one word on m_*). cfg_* sets lap length and station count;
// the user must write cfg_* only while the block is idle, as the block does
// not enforce it. Writes take effect at once. Flow: a write word is taken in
// idle and loads the table. A sample runs a wrap step (a 32-step divide
// unless the lap length is zero), a table scan with a read state and a check
// state per entry, a 45-step divide when it lands between two breakpoints,
// and a hand-off to the output register.
// One word is in work at a time: s_ready is high only while the sequencer is
// idle, so a new word waits until the last one reaches the output register.
// The finished word sits in the output register; a new input word is accepted
// while it waits, and the sequencer holds its next result until m_ready frees
// the register. Reset clears the configuration registers, the sequencer and
// m_valid; table contents are undefined until written.
// ----------------------------------------------------------------------------
module wrapped_breakpoint_interpolator_top
    import bpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bpi_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bpi_out_t              m_data
);

    bpi_cmd_t cmd;
    bpi_sts_t sts;

    bpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bpi_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== rtl/core/bpi_div.sv =====
// ----------------------------------------------------------------------------
// bpi_div
// Restoring divider, one quotient bit per cycle. Shared by the lap wrap
// (remainder) and the interpolation (quotient).
// ----------------------------------------------------------------------------
module bpi_div
    import bpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIV_CNT_W-1:0]  iters,
    input  logic [DIV_W-1:0]      dividend,
    input  logic [POS_W-1:0]      divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient,
    output logic [POS_W-1:0]      remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [POS_W:0]       rem_reg;
    logic [POS_W-1:0]     dsr_reg;

    logic [POS_W:0]       rem_shift;
    logic                 ge;

    // trial subtract
    assign rem_shift = {rem_reg[POS_W-1:0], quo_reg[DIV_W-1]};
    assign ge        = rem_shift >= {1'b0, dsr_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[POS_W-1:0];

endmodule

// ===== rtl/core/bpi_datapath.sv =====
// ----------------------------------------------------------------------------
// bpi_datapath
// Configuration registers, breakpoint table, scan registers, multiplier,
// shared divider and the output register.
// ----------------------------------------------------------------------------
module bpi_datapath
    import bpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  bpi_in_t               s_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output bpi_out_t              m_data,
    input  bpi_cmd_t              cmd,
    output bpi_sts_t              sts
);

    localparam int AW = $clog2(MAX_STATIONS);

    // configuration
    logic [POS_W-1:0] len_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] n_eff;

    // table
    logic [POS_W-1:0] pos_mem [MAX_STATIONS];
    logic [VAL_W-1:0] val_mem [MAX_STATIONS];
    logic [POS_W-1:0] rd_pos_reg;
    logic [VAL_W-1:0] rd_val_reg;
    logic             wr_en;

    // sample state
    logic [QRY_W-1:0]  qry_reg;
    logic [QRY_W-1:0]  qry_abs;
    logic [POS_W-1:0]  d_reg;
    logic [POS_W-1:0]  d_next;
    logic [CNT_W-1:0]  k_reg;
    logic [POS_W-1:0]  pa_reg;
    logic [VAL_W-1:0]  va_reg;

    // interpolation
    logic [VAL_W:0]          diff;
    logic [POS_W-1:0]        off;
    logic signed [PROD_W-1:0] prod;
    logic [DIV_W-1:0]        prod_reg;
    logic [DIV_W-1:0]        prod_abs;
    logic [POS_W-1:0]        span_reg;
    logic                    neg_reg;
    logic [VAL_W:0]          quo_s;
    logic [VAL_W-1:0]        interp_val;
    logic [VAL_W-1:0]        res_reg;

    // divider
    logic                 div_start;
    logic [DIV_CNT_W-1:0] div_iters;
    logic [DIV_W-1:0]     div_dividend;
    logic [POS_W-1:0]     div_divisor;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic [POS_W-1:0]     div_rem;

    // output register
    logic                 out_valid_reg;
    bpi_out_t             out_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TRACK_LENGTH:  len_reg   <= cfg_wdata[POS_W-1:0];
                REG_STATION_COUNT: count_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_eff = (count_reg > MAX_STATIONS) ? CNT_W'(MAX_STATIONS) : count_reg;

    // table write on an accepted write word, read at the scan index
    assign wr_en = cmd.accept && (s_data.command == CMD_WRITE) &&
                   (32'(s_data.station_index) < MAX_STATIONS);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pos_mem[AW'(s_data.station_index)] <= s_data.station_position;
            val_mem[AW'(s_data.station_index)] <= s_data.station_value;
        end
        if (cmd.rd_en) begin
            rd_pos_reg <= pos_mem[AW'(k_reg)];
            rd_val_reg <= val_mem[AW'(k_reg)];
        end
    end

    // wrap: magnitude in, remainder folded for negative queries
    assign qry_abs = qry_reg[QRY_W-1] ? (~qry_reg + QRY_W'(1)) : qry_reg;
    always_comb begin
        if (len_reg == '0)
            d_next = '0;
        else if (qry_reg[QRY_W-1] && (div_rem != '0))
            d_next = len_reg - div_rem;
        else
            d_next = div_rem;
    end

    // multiply operands
    assign diff = {rd_val_reg[VAL_W-1], rd_val_reg} - {va_reg[VAL_W-1], va_reg};
    assign off  = d_reg - pa_reg;
    assign prod = $signed(diff) * $signed({1'b0, off});
    assign prod_abs = prod_reg[DIV_W-1] ? (~prod_reg + DIV_W'(1)) : prod_reg;

    // signed quotient, added to the lower value
    assign quo_s      = neg_reg ? (~div_quo[VAL_W:0] + (VAL_W+1)'(1)) : div_quo[VAL_W:0];
    assign interp_val = va_reg + quo_s[VAL_W-1:0];

    // sample registers
    always_ff @(posedge aclk) begin
        if (cmd.accept)
            qry_reg <= s_data.query_position;
        if (cmd.wrap_latch) begin
            d_reg <= d_next;
            k_reg <= '0;
        end
        if (cmd.scan_adv) begin
            pa_reg <= rd_pos_reg;
            va_reg <= rd_val_reg;
            k_reg  <= k_reg + CNT_W'(1);
        end
        if (cmd.mul_en) begin
            prod_reg <= prod[DIV_W-1:0];
            span_reg <= rd_pos_reg - pa_reg;
            neg_reg  <= diff[VAL_W];
        end
        if (cmd.res_load) begin
            case (cmd.res_sel)
                RES_ENTRY:  res_reg <= rd_val_reg;
                RES_INTERP: res_reg <= interp_val;
                default:    res_reg <= '0;
            endcase
        end
        if (cmd.out_load) begin
            out_reg.sample_value     <= res_reg;
            out_reg.wrapped_position <= d_reg;
        end
    end

    // divider operand select
    assign div_start    = cmd.wrap_start || cmd.interp_start;
    assign div_iters    = cmd.interp_start ? INTERP_ITERS : WRAP_ITERS;
    assign div_dividend = cmd.interp_start ? prod_abs : {qry_abs, {WRAP_PAD{1'b0}}};
    assign div_divisor  = cmd.interp_start ? span_reg : len_reg;

    bpi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .iters     (div_iters),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // status
    assign sts.sample_cmd = s_data.command;
    assign sts.len_zero   = (len_reg == '0);
    assign sts.n_zero     = (n_eff == '0);
    assign sts.div_busy   = div_busy;
    assign sts.div_done   = div_done;
    assign sts.hit        = rd_pos_reg > d_reg;
    assign sts.k_zero     = (k_reg == '0);
    assign sts.last       = ((k_reg + CNT_W'(1)) == n_eff);
    assign sts.out_free   = !out_valid_reg || m_ready;

endmodule

// ===== rtl/core/bpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpi_ctrl
// Sequencer: wrap, table scan, interpolation divide and result hand-off.
// ----------------------------------------------------------------------------
module bpi_ctrl
    import bpi_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bpi_sts_t sts,
    output bpi_cmd_t cmd
);

    bpi_state_t state_reg;
    bpi_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (sts.sample_cmd == CMD_SAMPLE)
                        state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (sts.len_zero) begin
                    cmd.wrap_latch = 1'b1;
                    state_next     = ST_SCAN_RD;
                end else begin
                    cmd.wrap_start = 1'b1;
                    state_next     = ST_WRAP_WAIT;
                end
            end
            ST_WRAP_WAIT: begin
                if (sts.div_done) begin
                    cmd.wrap_latch = 1'b1;
                    state_next     = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (sts.n_zero) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ZERO;
                    state_next   = ST_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (sts.hit) begin
                    if (sts.k_zero) begin
                        // before the first breakpoint
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ENTRY;
                        state_next   = ST_FINISH;
                    end else begin
                        cmd.mul_en = 1'b1;
                        state_next = ST_DIV_START;
                    end
                end else begin
                    cmd.scan_adv = 1'b1;
                    if (sts.last) begin
                        // past the last breakpoint
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ENTRY;
                        state_next   = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_DIV_START: begin
                cmd.interp_start = 1'b1;
                state_next       = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_INTERP;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // divider is never restarted mid-run
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wrap_start || cmd.interp_start) |-> !sts.div_busy)
        else $error("divider started while busy");

    // output register only loaded when free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output word overwritten");

    // interpolation result goes straight to hand-off
    a_div_to_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_WAIT && sts.div_done) |=> (state_reg == ST_FINISH))
        else $error("interpolation result not handed off");

endmodule

// ===== tb/bpi_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpi_checker
// Watches the config port and both channels of the breakpoint interpolator.
// Keeps its own copy of registers and breakpoint table, computes the expected
// word for every accepted sample and compares it with the next output word.
// ----------------------------------------------------------------------------
module bpi_checker
    import bpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  bpi_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  bpi_out_t              m_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int SLOTS = 16;

    logic [POS_W-1:0]        lap_len;
    logic [CNT_W-1:0]        used_count;
    logic [POS_W-1:0]        bp_pos [SLOTS];
    logic signed [VAL_W-1:0] bp_val [SLOTS];
    bpi_out_t                expected_words [$];

    assign pending = expected_words.size();

    // expected output word for one sample
    function automatic bpi_out_t interp_sample(logic signed [QRY_W-1:0] q);
        longint   len, r, pa, pb, va, vb, span, acc;
        int       n, k;
        bpi_out_t o;
        len = longint'(lap_len);
        if (len == 0) begin
            r = 0;
        end else begin
            r = longint'(q) % len;
            if (r < 0) r += len;
        end
        n = (used_count > SLOTS) ? SLOTS : int'(used_count);
        k = 0;
        acc = 0;
        if (n != 0) begin
            while (k < n && !(longint'(bp_pos[k]) > r)) k++;
            if (k == 0) begin
                acc = longint'(bp_val[0]);
            end else if (k == n) begin
                acc = longint'(bp_val[n-1]);
            end else begin
                pa = longint'(bp_pos[k-1]);
                pb = longint'(bp_pos[k]);
                va = longint'(bp_val[k-1]);
                vb = longint'(bp_val[k]);
                span = pb - pa;
                if (span < 1) span = 1;
                acc = va + ((vb - va) * (r - pa)) / span;
                if (acc > 32767) acc = 32767;
                if (acc < -32768) acc = -32768;
            end
        end
        o.sample_value     = acc[VAL_W-1:0];
        o.wrapped_position = r[POS_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // track config, table writes and samples; compare output words
    always @(posedge aclk) begin
        bpi_out_t want;
        if (!aresetn) begin
            lap_len    <= '0;
            used_count <= '0;
            fail_count = 0;
            expected_words.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TRACK_LENGTH) lap_len <= cfg_wdata[POS_W-1:0];
                else if (cfg_index == REG_STATION_COUNT) used_count <= cfg_wdata[CNT_W-1:0];
            end
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_WRITE) begin
                    bp_pos[s_data.station_index] <= s_data.station_position;
                    bp_val[s_data.station_index] <= s_data.station_value;
                end else begin
                    expected_words.push_back(interp_sample(s_data.query_position));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t ns: output word with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.sample_value !== want.sample_value)
                        report_mismatch("sample_value", m_data.sample_value,
                                        want.sample_value);
                    if (m_data.wrapped_position !== want.wrapped_position)
                        report_mismatch("wrapped_position", m_data.wrapped_position,
                                        want.wrapped_position);
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the wrapped breakpoint interpolator. Loads breakpoint tables,
// sweeps lap length and station count through several settings and sends
// directed then random write and sample words under random stalls on both
// sides. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import bpi_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    bpi_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    bpi_out_t              m_data;
    int                    fail_count;
    int                    pending;

    int               send_idle;
    int               recv_idle;
    logic [POS_W-1:0] cur_len;
    logic [POS_W-1:0] pos_copy [16];

    wrapped_breakpoint_interpolator_top dut (.*);

    bpi_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // overall time limit
    initial begin
        #40ms;
        $display("wrapped_breakpoint_interpolator_top regression: fail");
        $finish;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // send one word, then maybe idle
    task automatic put_word(bpi_in_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic put_write(int idx, logic [POS_W-1:0] p, logic signed [VAL_W-1:0] v);
        bpi_in_t w;
        w = '0;
        w.command          = CMD_WRITE;
        w.station_index    = IDX_W'(idx);
        w.station_position = p;
        w.station_value    = v;
        w.query_position   = $urandom;
        pos_copy[idx] = p;
        put_word(w);
    endtask

    task automatic put_sample(logic signed [QRY_W-1:0] q);
        bpi_in_t w;
        w = '0;
        w.command          = CMD_SAMPLE;
        w.station_index    = IDX_W'($urandom);
        w.station_position = POS_W'($urandom);
        w.station_value    = VAL_W'($urandom);
        w.query_position   = q;
        put_word(w);
    endtask

    // hold off until every result is back and the block has settled
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // sorted table with random values and positions in [0, 16 * (lim / 17 + 1)]
    task automatic load_sorted(logic [POS_W-1:0] lim);
        logic [POS_W-1:0] p;
        longint           step;
        step = (longint'(lim) / 17) + 1;
        p = POS_W'($urandom_range(int'(step)));
        for (int i = 0; i < 16; i++) begin
            put_write(i, p, VAL_W'($urandom));
            // an occasional duplicate gives a zero span
            if ($urandom_range(7) != 0) p = p + POS_W'($urandom_range(int'(step)));
        end
    endtask

    function automatic logic signed [QRY_W-1:0] pick_query();
        logic signed [QRY_W-1:0] q;
        case ($urandom_range(3))
            0: q = $urandom;
            1: q = QRY_W'(pos_copy[$urandom_range(15)]) + $urandom_range(4) - 2;
            2: q = (cur_len != 0) ? QRY_W'($urandom_range(int'(cur_len) - 1)) : $urandom;
            default: q = (cur_len != 0)
                ? QRY_W'(pos_copy[$urandom_range(15)]) - QRY_W'(cur_len) * $urandom_range(3)
                : -QRY_W'($urandom_range(1000));
        endcase
        return q;
    endfunction

    // stimulus
    initial begin
        logic [POS_W-1:0] len_set [6];
        logic [CNT_W-1:0] cnt_set [6];
        int               wait_cycles;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        send_idle = 13;
        recv_idle = 76;
        cur_len   = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table with no lap length
        put_sample(32'sd12345);
        drain();
        cur_len = 28'hFFFFFFF;
        set_reg(REG_TRACK_LENGTH, cur_len);
        set_reg(REG_STATION_COUNT, 5'd16);
        // extreme values, a zero span and the top position
        for (int i = 0; i < 16; i++) begin
            put_write(i, (i == 15) ? 28'hFFFFFFF :
                         (i == 2) ? 28'd1100 : POS_W'(100 + i * 1000),
                      (i % 2 == 0) ? -16'sd32768 : 16'sd32767);
        end
        put_sample(32'sd50);            // ahead of the first breakpoint
        put_sample(32'sd100);           // exactly on one
        put_sample(32'sd600);           // between extreme values
        put_sample(32'sd1100);          // on the duplicated position
        put_sample(32'sh7FFFFFFF);
        put_sample(32'sh80000000);
        put_sample(-32'sd1);            // wraps to the top of the lap
        put_sample(32'sh0FFFFFFE);      // between the last two breakpoints
        drain();

        len_set = '{28'hFFFFFFF, 28'd0, 28'd5000, 28'd1, 28'h0123456, 28'd100000};
        cnt_set = '{5'd16, 5'd5, 5'd31, 5'd0, 5'd1, 5'd2};
        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph < 2) ? 13 : (ph < 4) ? 76 : 0;
            recv_idle = (ph < 2) ? 76 : (ph < 4) ? 13 : 0;
            drain();
            cur_len = len_set[ph];
            set_reg(REG_TRACK_LENGTH, cur_len);
            set_reg(REG_STATION_COUNT, (ph == 5) ? CNT_W'($urandom_range(2, 16)) : cnt_set[ph]);
            load_sorted((cur_len != 0) ? cur_len : 28'hFFFFF);
            for (int n = 0; n < 205; n++) begin
                if ($urandom_range(9) < 2)
                    put_write($urandom_range(15), POS_W'($urandom), VAL_W'($urandom));
                else
                    put_sample(pick_query());
            end
        end

        // wind down
        s_valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("wrapped_breakpoint_interpolator_top regression: pass");
        end else begin
            $display("wrapped_breakpoint_interpolator_top regression: fail");
        end
        $finish;
    end

endmodule
